@@ sv/timer_prescaler_reload_solver_macros.svh @@
// Assertion macros shared by the timer setting solver RTL.
`ifndef TIMER_PRESCALER_RELOAD_SOLVER_MACROS_SVH
`define TIMER_PRESCALER_RELOAD_SOLVER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define TPRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer solver assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TPRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer solver assertion failed");

`else

`define TPRS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TPRS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/tprs_pkg.sv @@
// Types and constants shared by the timer setting solver modules.
package tprs_pkg;

  localparam int unsigned DIV_BITS = 32;
  localparam int unsigned CNT_BITS = $clog2(DIV_BITS);
  localparam logic [DIV_BITS-1:0] BASE_CLOCK_RESET = 32'd50000000;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_UNREACHABLE = 2'd1,
    STATUS_ZERO_FREQ   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_BASE,
    ST_CHECK,
    ST_DIV_STEP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start_base;
    logic    start_step;
    logic    load_divider;
    logic    load_reload;
    logic    finish;
    status_t result;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic reload_over;
    logic presc_full;
    logic tick_zero;
  } stat_t;

endpackage

@@ sv/tprs_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module tprs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tprs_pkg::DIV_BITS-1:0] dividend,
  input  logic [tprs_pkg::DIV_BITS-1:0] divisor,
  output logic                          done,
  output logic [tprs_pkg::DIV_BITS-1:0] quotient
);
  import tprs_pkg::*;

  logic                active;
  logic [CNT_BITS-1:0] count;
  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] quo;
  logic [DIV_BITS-1:0] dsr;
  logic [DIV_BITS:0]   shifted;
  logic [DIV_BITS:0]   diff;
  logic                fits;

  assign shifted  = {rem, quo[DIV_BITS-1]};
  assign diff     = shifted - {1'b0, dsr};
  assign fits     = !diff[DIV_BITS];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= '0;
      end else if (active) begin
        count <= count + CNT_BITS'(1);
        if (count == CNT_BITS'(DIV_BITS - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // The partial remainder never reaches the divisor, so it fits the word.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (active) begin
      rem <= fits ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
      quo <= {quo[DIV_BITS-2:0], fits};
    end
  end

endmodule

@@ sv/tprs_datapath.sv @@
// Datapath: clock register, divider, prescaler search registers and result registers.
module tprs_datapath #(
  parameter int unsigned PRESCALER_BITS = 8,
  parameter int unsigned RELOAD_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          base_clock_hz_we,
  input  logic [tprs_pkg::DIV_BITS-1:0] base_clock_hz,
  input  logic [tprs_pkg::DIV_BITS-1:0] tick_hz,
  input  tprs_pkg::cmd_t                cmd,
  output tprs_pkg::stat_t               stat,
  output logic                          done,
  output logic [PRESCALER_BITS-1:0]     prescaler_value,
  output logic [RELOAD_BITS-1:0]        reload_value,
  output logic [1:0]                    status
);
  import tprs_pkg::*;

  localparam logic [DIV_BITS:0] RELOAD_MAX =
    (33'd1 << RELOAD_BITS) - 33'd1;

  logic [DIV_BITS-1:0]       base_clk;
  logic [DIV_BITS-1:0]       divider;
  logic [DIV_BITS-1:0]       reload;
  logic [PRESCALER_BITS-1:0] presc;
  logic [PRESCALER_BITS:0]   presc_inc;
  logic [PRESCALER_BITS:0]   step_div;
  logic                      div_start;
  logic [DIV_BITS-1:0]       div_dividend;
  logic [DIV_BITS-1:0]       div_divisor;
  logic                      div_done;
  logic [DIV_BITS-1:0]       div_quo;

  assign presc_inc    = {1'b0, presc} + (PRESCALER_BITS + 1)'(1);
  // A step raises the prescaler by one and divides by the raised value plus one.
  assign step_div     = {1'b0, presc} + (PRESCALER_BITS + 1)'(2);
  assign div_start    = cmd.start_base | cmd.start_step;
  assign div_dividend = cmd.start_base ? base_clk : divider;
  assign div_divisor  = cmd.start_base ? tick_hz : DIV_BITS'(step_div);

  tprs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    stat.div_done    = div_done;
    stat.reload_over = {1'b0, reload} > RELOAD_MAX;
    stat.presc_full  = presc == {PRESCALER_BITS{1'b1}};
    stat.tick_zero   = tick_hz == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_clk <= BASE_CLOCK_RESET;
    end else if (base_clock_hz_we) begin
      base_clk <= base_clock_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_divider) begin
      divider <= div_quo;
      presc   <= '0;
      reload  <= div_quo - DIV_BITS'(1);
    end else begin
      if (cmd.start_step) begin
        presc <= presc_inc[PRESCALER_BITS-1:0];
      end
      if (cmd.load_reload) begin
        reload <= div_quo - DIV_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= cmd.result;
      if (cmd.result == STATUS_OK) begin
        prescaler_value <= presc;
        reload_value    <= reload[RELOAD_BITS-1:0];
      end else begin
        prescaler_value <= '0;
        reload_value    <= '0;
      end
    end
  end

endmodule

@@ sv/tprs_ctrl.sv @@
// Controller: sequences the divider through the prescaler search.
module tprs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tprs_pkg::stat_t stat,
  output tprs_pkg::cmd_t  cmd,
  output logic            busy
);
  import tprs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && !stat.tick_zero) begin
          state_next = ST_DIV_BASE;
        end
      end
      ST_DIV_BASE, ST_DIV_STEP: begin
        if (stat.div_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.reload_over && !stat.presc_full) begin
          state_next = ST_DIV_STEP;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.result = STATUS_OK;
    busy       = state != ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (stat.tick_zero) begin
            cmd.finish = 1'b1;
            cmd.result = STATUS_ZERO_FREQ;
          end else begin
            cmd.start_base = 1'b1;
          end
        end
      end
      ST_DIV_BASE: cmd.load_divider = stat.div_done;
      ST_DIV_STEP: cmd.load_reload  = stat.div_done;
      ST_CHECK: begin
        if (stat.reload_over && !stat.presc_full) begin
          cmd.start_step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          cmd.result = stat.reload_over ? STATUS_UNREACHABLE : STATUS_OK;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/timer_prescaler_reload_solver.sv @@
// Top level of the timer setting solver: controller plus datapath.
// A zero tick_hz gives its result in the cycle after it is accepted. Otherwise the
// base division runs and its result is checked, and each prescaler step repeats the
// division and the check until the reload fits or the prescaler is full.
// The shared 32-bit divider computes one quotient bit per clock; one item
// is in flight at a time and busy stays high until its result is produced.
// Reset clears the controller and restores base_clock_hz to 50 MHz; results cannot be stalled.
`include "timer_prescaler_reload_solver_macros.svh"

module timer_prescaler_reload_solver #(
  parameter int unsigned PRESCALER_BITS = 8,
  parameter int unsigned RELOAD_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          base_clock_hz_we,
  input  logic [tprs_pkg::DIV_BITS-1:0] base_clock_hz,
  input  logic                          start,
  input  logic [tprs_pkg::DIV_BITS-1:0] tick_hz,
  output logic                          busy,
  output logic                          done,
  output logic [PRESCALER_BITS-1:0]     prescaler_value,
  output logic [RELOAD_BITS-1:0]        reload_value,
  output logic [1:0]                    status
);
  import tprs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller walks the prescaler upward one step per division until the
  // reload fits or the prescaler runs out; the datapath holds all the numbers.
  tprs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tprs_datapath #(
    .PRESCALER_BITS (PRESCALER_BITS),
    .RELOAD_BITS    (RELOAD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .base_clock_hz_we (base_clock_hz_we),
    .base_clock_hz    (base_clock_hz),
    .tick_hz          (tick_hz),
    .cmd              (cmd),
    .stat             (stat),
    .done             (done),
    .prescaler_value  (prescaler_value),
    .reload_value     (reload_value),
    .status           (status)
  );

  // An error result always carries cleared settings.
  `TPRS_ASSERT_IMPL(a_err_zero, clk, rst, done && (status != STATUS_OK), (prescaler_value == '0) && (reload_value == '0))
  // A zero tick frequency is answered in the very next cycle.
  `TPRS_ASSERT_NEXT(a_zero_fast, clk, rst, start && !busy && (tick_hz == '0), done && (status == STATUS_ZERO_FREQ))
  // A nonzero tick frequency starts a search.
  `TPRS_ASSERT_NEXT(a_search_busy, clk, rst, start && !busy && (tick_hz != '0), busy && !done)

endmodule
